// ----- sv/gcdlcm_pkg.sv -----
// shared types, step codes and microcode table for the gcd / lcm unit
package gcdlcm_pkg;

    // width of the operand and result ports
    localparam int FIELD_W = 64;

    // microprogram sequencer
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // datapath actions, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_GSTEP,
        OP_GFIN,
        OP_DINIT,
        OP_DSTEP,
        OP_MINIT,
        OP_MSTEP,
        OP_LFIN,
        OP_GOUT,
        OP_ZOUT,
        OP_EMIT
    } dp_op_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_START,
        C_GCD_RUN,
        C_IS_GCD,
        C_ANY_ZERO,
        C_CNT_RUN,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        step_t  target;
    } ucw_t;

    // step addresses
    localparam step_t S_WAIT  = step_t'(0);
    localparam step_t S_GCD   = step_t'(1);
    localparam step_t S_GFIN  = step_t'(2);
    localparam step_t S_ZCHK  = step_t'(3);
    localparam step_t S_DINIT = step_t'(4);
    localparam step_t S_DIV   = step_t'(5);
    localparam step_t S_MINIT = step_t'(6);
    localparam step_t S_MUL   = step_t'(7);
    localparam step_t S_LFIN  = step_t'(8);
    localparam step_t S_GOUT  = step_t'(9);
    localparam step_t S_ZOUT  = step_t'(10);
    localparam step_t S_EMIT  = step_t'(11);
    localparam step_t S_RET   = step_t'(12);

    // microprogram: on a true condition jump to target, else fall through
    function automatic ucw_t ucode_rom(input step_t pc);
        ucw_t w;
        begin
            case (pc)
                S_WAIT:  w = '{op: OP_LOAD,  cond: C_NOT_START, target: S_WAIT};
                S_GCD:   w = '{op: OP_GSTEP, cond: C_GCD_RUN,   target: S_GCD};
                S_GFIN:  w = '{op: OP_GFIN,  cond: C_IS_GCD,    target: S_GOUT};
                S_ZCHK:  w = '{op: OP_NOP,   cond: C_ANY_ZERO,  target: S_ZOUT};
                S_DINIT: w = '{op: OP_DINIT, cond: C_NEVER,     target: S_WAIT};
                S_DIV:   w = '{op: OP_DSTEP, cond: C_CNT_RUN,   target: S_DIV};
                S_MINIT: w = '{op: OP_MINIT, cond: C_NEVER,     target: S_WAIT};
                S_MUL:   w = '{op: OP_MSTEP, cond: C_CNT_RUN,   target: S_MUL};
                S_LFIN:  w = '{op: OP_LFIN,  cond: C_ALWAYS,    target: S_EMIT};
                S_GOUT:  w = '{op: OP_GOUT,  cond: C_ALWAYS,    target: S_EMIT};
                S_ZOUT:  w = '{op: OP_ZOUT,  cond: C_NEVER,     target: S_WAIT};
                S_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_BUSY,  target: S_EMIT};
                S_RET:   w = '{op: OP_NOP,   cond: C_ALWAYS,    target: S_WAIT};
                default: w = '{op: OP_NOP,   cond: C_ALWAYS,    target: S_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

// ----- sv/gcd_lcm_unit.sv -----
// gcd / lcm unit: microcoded sequencer over a shift, add and compare datapath
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_ready  | operation, operand_a, operand_b
//   out     | out_valid / out_ready| value, overflow
//
// one item at a time; gcd runs the binary gcd loop (one shift or one subtract
// per step), then the gcd finish, gcd output and emit steps
// lcm adds one restoring divide and one shift-add multiply over DATA_WIDTH bits
// each, plus 4 control steps in place of the gcd output step; an lcm with a zero
// operand goes from the zero check straight to the zero output step
// in_ready is high only on the wait step; the output register lets a new item
// in while an earlier result is still waiting for out_ready
// a finished result stalls on the emit step while the output register is full
// rst_n clears the step counter and out_valid; no clearing pass is needed
module gcd_lcm_unit #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic                                       operation,
    input  logic signed [gcdlcm_pkg::FIELD_W-1:0]      operand_a,
    input  logic signed [gcdlcm_pkg::FIELD_W-1:0]      operand_b,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic signed [gcdlcm_pkg::FIELD_W-1:0]      value,
    output logic                                       overflow
);
    import gcdlcm_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);
    localparam logic [DATA_WIDTH-1:0] SIGN_BIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // sequencer
    step_t pc_reg, pc_next;
    ucw_t  ucw;

    // datapath: x/y serve as gcd pair, then remainder/quotient, then product hi/lo
    logic [DATA_WIDTH-1:0] x_reg, x_next;
    logic [DATA_WIDTH-1:0] y_reg, y_next;
    logic [DATA_WIDTH-1:0] ma_reg, ma_next;
    logic [DATA_WIDTH-1:0] mb_reg, mb_next;
    logic [DATA_WIDTH-1:0] g_reg, g_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  a_neg_reg, a_neg_next;
    logic                  b_neg_reg, b_neg_next;
    logic                  lcm_reg, lcm_next;
    logic [DATA_WIDTH-1:0] res_val_reg, res_val_next;
    logic                  res_ovf_reg, res_ovf_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic signed [FIELD_W-1:0]     out_value_reg, out_value_next;
    logic                          out_ovf_reg, out_ovf_next;

    // operand magnitudes at the low DATA_WIDTH bits
    logic [DATA_WIDTH-1:0] a_w, b_w, a_mag, b_mag;

    // shared arithmetic
    logic [DATA_WIDTH:0]   diff;
    logic [DATA_WIDTH:0]   div_shift;
    logic [DATA_WIDTH:0]   div_sub;
    logic [DATA_WIDTH:0]   mul_sum;
    logic [DATA_WIDTH-1:0] lim;
    logic                  neg;
    logic                  out_busy;
    logic                  cond_true;

    assign ucw = ucode_rom(pc_reg);

    assign a_w   = operand_a[DATA_WIDTH-1:0];
    assign b_w   = operand_b[DATA_WIDTH-1:0];
    assign a_mag = a_w[DATA_WIDTH-1] ? (~a_w + 1'b1) : a_w;
    assign b_mag = b_w[DATA_WIDTH-1] ? (~b_w + 1'b1) : b_w;

    assign diff      = {1'b0, x_reg} - {1'b0, y_reg};
    assign div_shift = {x_reg, y_reg[DATA_WIDTH-1]};
    assign div_sub   = div_shift - {1'b0, g_reg};
    assign mul_sum   = {1'b0, x_reg} + (y_reg[0] ? {1'b0, mb_reg} : '0);
    assign neg       = a_neg_reg ^ b_neg_reg;
    assign lim       = neg ? SIGN_BIT : (SIGN_BIT - 1'b1);

    assign out_busy = out_valid_reg && !out_ready;
    assign in_ready = (pc_reg == S_WAIT);

    // jump condition select
    always_comb
    begin
        case (ucw.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_NOT_START: cond_true = !in_valid;
            C_GCD_RUN:   cond_true = (x_reg != '0) && (y_reg != '0);
            C_IS_GCD:    cond_true = !lcm_reg;
            C_ANY_ZERO:  cond_true = (ma_reg == '0) || (mb_reg == '0);
            C_CNT_RUN:   cond_true = (cnt_reg != CNT_LAST);
            C_OUT_BUSY:  cond_true = out_busy;
            default:     cond_true = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        if (cond_true)
        begin
            pc_next = ucw.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    // datapath actions
    always_comb
    begin
        x_next         = x_reg;
        y_next         = y_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        g_next         = g_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        a_neg_next     = a_neg_reg;
        b_neg_next     = b_neg_reg;
        lcm_next       = lcm_reg;
        res_val_next   = res_val_reg;
        res_ovf_next   = res_ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_ovf_next   = out_ovf_reg;

        case (ucw.op)
            OP_LOAD:
            begin
                if (in_valid)
                begin
                    x_next     = a_mag;
                    y_next     = b_mag;
                    ma_next    = a_mag;
                    mb_next    = b_mag;
                    a_neg_next = a_w[DATA_WIDTH-1];
                    b_neg_next = b_w[DATA_WIDTH-1];
                    lcm_next   = operation;
                    k_next     = '0;
                end
            end
            OP_GSTEP:
            begin
                // binary gcd: strip common twos, halve even sides, subtract odd pair
                if ((x_reg != '0) && (y_reg != '0))
                begin
                    if (!x_reg[0] && !y_reg[0])
                    begin
                        x_next = x_reg >> 1;
                        y_next = y_reg >> 1;
                        k_next = k_reg + 1'b1;
                    end
                    else if (!x_reg[0])
                    begin
                        x_next = x_reg >> 1;
                    end
                    else if (!y_reg[0])
                    begin
                        y_next = y_reg >> 1;
                    end
                    else if (!diff[DATA_WIDTH])
                    begin
                        x_next = diff[DATA_WIDTH-1:0];
                    end
                    else
                    begin
                        y_next = ~diff[DATA_WIDTH-1:0] + 1'b1;
                    end
                end
            end
            OP_GFIN:
            begin
                g_next = (x_reg | y_reg) << k_reg;
            end
            OP_DINIT:
            begin
                x_next   = '0;
                y_next   = ma_reg;
                cnt_next = '0;
            end
            OP_DSTEP:
            begin
                // restoring divide, one quotient bit per step
                if (!div_sub[DATA_WIDTH])
                begin
                    x_next = div_sub[DATA_WIDTH-1:0];
                    y_next = {y_reg[DATA_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    x_next = div_shift[DATA_WIDTH-1:0];
                    y_next = {y_reg[DATA_WIDTH-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            OP_MINIT:
            begin
                // quotient stays in y as multiplier
                x_next   = '0;
                cnt_next = '0;
            end
            OP_MSTEP:
            begin
                x_next   = mul_sum[DATA_WIDTH:1];
                y_next   = {mul_sum[0], y_reg[DATA_WIDTH-1:1]};
                cnt_next = cnt_reg + 1'b1;
            end
            OP_LFIN:
            begin
                res_ovf_next = (x_reg != '0) || (y_reg > lim);
                res_val_next = neg ? (~y_reg + 1'b1) : y_reg;
            end
            OP_GOUT:
            begin
                res_val_next = g_reg;
                res_ovf_next = g_reg[DATA_WIDTH-1];
            end
            OP_ZOUT:
            begin
                res_val_next = '0;
                res_ovf_next = 1'b0;
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = FIELD_W'($signed(res_val_reg));
                    out_ovf_next   = res_ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= S_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        ma_reg        <= ma_next;
        mb_reg        <= mb_next;
        g_reg         <= g_next;
        k_reg         <= k_next;
        cnt_reg       <= cnt_next;
        a_neg_reg     <= a_neg_next;
        b_neg_reg     <= b_neg_next;
        lcm_reg       <= lcm_next;
        res_val_reg   <= res_val_next;
        res_ovf_reg   <= res_ovf_next;
        out_value_reg <= out_value_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign overflow  = out_ovf_reg;

    // an accepted item always enters the gcd loop next
    a_accept_to_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> pc_reg == S_GCD)
        else $error("accepted item did not start the gcd loop");

    // gcd loop leaves only once one side has reached zero
    a_gcd_done: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == S_GFIN |-> (x_reg == '0) || (y_reg == '0))
        else $error("gcd finish reached with both sides nonzero");

    // the divide never runs against a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == S_DIV |-> g_reg != '0)
        else $error("divide step with zero gcd");

    // a new result appears only from the emit step
    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pc_reg) == S_EMIT)
        else $error("result valid raised outside the emit step");

endmodule
